/* sv/psg_pkg.sv */
// ----------------------------------------------------------------------------
// psg_pkg
// Shared types, codes and constants of the tone/noise sound generator.
// ----------------------------------------------------------------------------
package psg_pkg;

	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 8;
	localparam int PERIOD_W  = 10;
	localparam int LEVEL_W   = 13;
	localparam int SUM_W     = 16;
	localparam int SAMPLE_W  = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_STEREO_ENABLES = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE    = 8'd1;

	localparam logic [15:0] NOISE_SEED   = 16'h8000;
	localparam logic [15:0] TAP_WHITE    = 16'h9000;
	localparam logic [15:0] TAP_PERIODIC = 16'h8000;

	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_0 = 10'h010;
	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_1 = 10'h020;
	localparam logic [PERIOD_W-1:0] NOISE_RELOAD_2 = 10'h040;

	localparam logic [3:0] ATT_SILENT = 4'd15;

	localparam logic signed [SUM_W-1:0] SAMPLE_MAX = 16'sd8191;
	localparam logic signed [SUM_W-1:0] SAMPLE_MIN = -16'sd8192;

	// 10^(-a/10) in unsigned Q1.24
	localparam logic [24:0] ATT_RATIO_Q24 [15] = '{
		25'd16777216, 25'd13326616, 25'd10585708, 25'd8408526, 25'd6679130,
		25'd5305422,  25'd4214246,  25'd3347495,  25'd2659010, 25'd2112126,
		25'd1677722,  25'd1332662,  25'd1058571,  25'd840853,  25'd667913
	};

	typedef enum logic [2:0] {
		OP_TICK,
		OP_TONE_LO,
		OP_TONE_HI,
		OP_ATT,
		OP_NOISE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] chan;
		logic [5:0] val;
	} entry_t;

	typedef struct packed {
		logic [7:0] enables;
		logic       mode;
	} mix_cfg_t;

	// Elaboration-time level of one attenuation step
	function automatic logic [LEVEL_W-1:0] level_of(input int full_scale, input int att);
		logic [63:0] v;
		v = 64'd0;
		if (att < 15) begin
			v = 64'(full_scale) * 64'(ATT_RATIO_Q24[att]) + 64'h0080_0000;
		end
		return v[24 +: LEVEL_W];
	endfunction

endpackage

/* sv/psg_in_if.sv */
// ----------------------------------------------------------------------------
// psg_in_if
// Command channel: a register write byte or one sound-clock tick per item.
// ----------------------------------------------------------------------------
interface psg_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] data;

	modport source (output valid, output cmd, output data, input ready);
	modport sink   (input valid, input cmd, input data, output ready);
endinterface

/* sv/psg_out_if.sv */
// ----------------------------------------------------------------------------
// psg_out_if
// Sample channel: one signed stereo pair per item.
// ----------------------------------------------------------------------------
interface psg_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [psg_pkg::SAMPLE_W-1:0]    left_sample;
	logic signed [psg_pkg::SAMPLE_W-1:0]    right_sample;

	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* sv/psg_cfg_if.sv */
// ----------------------------------------------------------------------------
// psg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface psg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [psg_pkg::CFG_IDX_W-1:0]   index;
	logic [psg_pkg::CFG_DAT_W-1:0]   wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* sv/psg_front.sv */
// ----------------------------------------------------------------------------
// psg_front
// Accepts command items, tracks the latched register and classifies each
// write byte into the field it updates.
// ----------------------------------------------------------------------------
module psg_front (
	input  logic             clk,
	input  logic             arst_n,
	psg_in_if.sink           item_in,
	output logic             push_valid,
	input  logic             push_ready,
	output psg_pkg::entry_t  push_entry
);

	logic [2:0] latched_q;
	logic [2:0] lat;
	logic       accept;

	assign item_in.ready = push_ready;
	assign push_valid    = item_in.valid;
	assign accept        = item_in.valid & push_ready;
	assign lat           = item_in.data[7] ? item_in.data[6:4] : latched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= 3'd0;
		end else if (accept && !item_in.cmd && item_in.data[7]) begin
			latched_q <= item_in.data[6:4];
		end
	end

	always_comb begin
		push_entry.chan = lat[2:1];
		push_entry.val  = item_in.data[5:0];
		if (item_in.cmd) begin
			push_entry.op = psg_pkg::OP_TICK;
		end else if (lat[0]) begin
			push_entry.op = psg_pkg::OP_ATT;
		end else if (lat[2:1] == 2'd3) begin
			push_entry.op = psg_pkg::OP_NOISE;
		end else if (item_in.data[7]) begin
			push_entry.op = psg_pkg::OP_TONE_LO;
		end else begin
			push_entry.op = psg_pkg::OP_TONE_HI;
		end
	end

endmodule

/* sv/psg_queue.sv */
// ----------------------------------------------------------------------------
// psg_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module psg_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  psg_pkg::entry_t  push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output psg_pkg::entry_t  pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	psg_pkg::entry_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push_fire;
	logic               pop_fire;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign push_fire  = push_valid & push_ready;
	assign pop_fire   = pop_valid & pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push_fire && !pop_fire) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

/* sv/psg_back.sv */
// ----------------------------------------------------------------------------
// psg_back
// Executes classified items: register updates, the tick of the four
// counters and noise shifter, level lookup, then mix and saturation.
// ----------------------------------------------------------------------------
module psg_back #(
	parameter int FULL_SCALE = 1536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  psg_pkg::entry_t    pop_entry,
	input  psg_pkg::mix_cfg_t  mix_cfg,
	psg_out_if.source          sample_out
);

	localparam int PW = psg_pkg::PERIOD_W;
	localparam int LW = psg_pkg::LEVEL_W;
	localparam int SW = psg_pkg::SUM_W;

	logic [LW-1:0] level_tab [16];

	for (genvar a = 0; a < 16; a++) begin : g_level
		localparam logic [LW-1:0] LVL = psg_pkg::level_of(FULL_SCALE, a);
		assign level_tab[a] = LVL;
	end

	// generator state
	logic [PW-1:0]  period_q [3];
	logic [3:0]     att_q    [4];
	logic [2:0]     nctl_q;
	logic [PW-1:0]  cnt_q    [4];
	logic [3:0]     pol_q;
	logic [15:0]    shift_q;
	logic           nbit_q;

	// next state on a tick
	logic [PW-1:0]  cnt_n [4];
	logic [PW-1:0]  dec   [4];
	logic [3:0]     pol_n;
	logic [15:0]    shift_n;
	logic           nbit_n;
	logic [PW-1:0]  noise_reload;

	// pipeline
	logic           valid_s1;
	logic [LW-1:0]  level_s1 [4];
	logic [3:0]     pos_s1;
	logic           out_valid_q;
	logic signed [psg_pkg::SAMPLE_W-1:0] left_q;
	logic signed [psg_pkg::SAMPLE_W-1:0] right_q;

	logic           ready_out;
	logic           ready_s1;
	logic           is_tick;
	logic           tick_fire;
	logic           wr_fire;

	logic signed [SW-1:0] part [4];
	logic signed [SW-1:0] sum_l;
	logic signed [SW-1:0] sum_r;
	logic signed [SW-1:0] sat_l;
	logic signed [SW-1:0] sat_r;

	assign ready_out = !out_valid_q || sample_out.ready;
	assign ready_s1  = !valid_s1 || ready_out;
	assign is_tick   = (pop_entry.op == psg_pkg::OP_TICK);
	assign pop_ready = is_tick ? ready_s1 : 1'b1;
	assign tick_fire = pop_valid & is_tick & ready_s1;
	assign wr_fire   = pop_valid & !is_tick;

	always_comb begin
		case (nctl_q[1:0])
			2'd0:    noise_reload = psg_pkg::NOISE_RELOAD_0;
			2'd1:    noise_reload = psg_pkg::NOISE_RELOAD_1;
			2'd2:    noise_reload = psg_pkg::NOISE_RELOAD_2;
			default: noise_reload = period_q[2];
		endcase
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			dec[c] = (cnt_q[c] != '0) ? cnt_q[c] - 1'b1 : '0;
		end
		for (int c = 0; c < 3; c++) begin
			cnt_n[c] = (dec[c] == '0) ? period_q[c] : dec[c];
			pol_n[c] = (dec[c] == '0) ? ~pol_q[c] : pol_q[c];
			if (period_q[c] <= PW'(1)) begin
				pol_n[c] = 1'b1;
			end
		end
		cnt_n[3] = (dec[3] == '0) ? noise_reload : dec[3];
		pol_n[3] = (dec[3] == '0) ? ~pol_q[3] : pol_q[3];
		shift_n  = shift_q;
		nbit_n   = nbit_q;
		if (dec[3] == '0 && pol_n[3]) begin
			nbit_n  = shift_q[0];
			shift_n = shift_q >> 1;
			if (shift_q[0]) begin
				shift_n = shift_n ^ (nctl_q[2] ? psg_pkg::TAP_WHITE : psg_pkg::TAP_PERIODIC);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				period_q[c] <= '0;
			end
			for (int c = 0; c < 4; c++) begin
				att_q[c] <= psg_pkg::ATT_SILENT;
				cnt_q[c] <= '0;
			end
			nctl_q      <= '0;
			pol_q       <= '1;
			shift_q     <= '0;
			nbit_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_fire) begin
				case (pop_entry.op)
					psg_pkg::OP_TONE_LO: period_q[pop_entry.chan][3:0] <= pop_entry.val[3:0];
					psg_pkg::OP_TONE_HI: period_q[pop_entry.chan][9:4] <= pop_entry.val;
					psg_pkg::OP_ATT:     att_q[pop_entry.chan] <= pop_entry.val[3:0];
					psg_pkg::OP_NOISE: begin
						nctl_q  <= pop_entry.val[2:0];
						shift_q <= psg_pkg::NOISE_SEED;
					end
					default: ;
				endcase
			end
			if (tick_fire) begin
				for (int c = 0; c < 4; c++) begin
					cnt_q[c] <= cnt_n[c];
				end
				pol_q   <= pol_n;
				shift_q <= shift_n;
				nbit_q  <= nbit_n;
			end
			if (ready_s1) begin
				valid_s1 <= tick_fire;
			end
			if (ready_out) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_fire) begin
			for (int c = 0; c < 4; c++) begin
				level_s1[c] <= level_tab[att_q[c]];
			end
			pos_s1 <= {nbit_n, pol_n[2:0]};
		end
		if (ready_out && valid_s1) begin
			left_q  <= sat_l[psg_pkg::SAMPLE_W-1:0];
			right_q <= sat_r[psg_pkg::SAMPLE_W-1:0];
		end
	end

	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int c = 0; c < 4; c++) begin
			part[c] = pos_s1[c] ? $signed(SW'(level_s1[c])) : -$signed(SW'(level_s1[c]));
			if (!mix_cfg.mode || mix_cfg.enables[c + 4]) begin
				sum_l = sum_l + part[c];
			end
			if (!mix_cfg.mode || mix_cfg.enables[c]) begin
				sum_r = sum_r + part[c];
			end
		end
		sat_l = (sum_l > psg_pkg::SAMPLE_MAX) ? psg_pkg::SAMPLE_MAX :
			(sum_l < psg_pkg::SAMPLE_MIN) ? psg_pkg::SAMPLE_MIN : sum_l;
		sat_r = (sum_r > psg_pkg::SAMPLE_MAX) ? psg_pkg::SAMPLE_MAX :
			(sum_r < psg_pkg::SAMPLE_MIN) ? psg_pkg::SAMPLE_MIN : sum_r;
	end

	assign sample_out.valid        = out_valid_q;
	assign sample_out.left_sample  = left_q;
	assign sample_out.right_sample = right_q;

	a_noise_seed: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_fire && pop_entry.op == psg_pkg::OP_NOISE) |=> shift_q == psg_pkg::NOISE_SEED)
		else $error("noise write did not reseed shifter");

	a_short_period: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_fire && period_q[0] <= PW'(1)) |=> pol_q[0])
		else $error("short tone period not held positive");

endmodule

/* sv/psg_tone_noise_mixer_core.sv */
// A tick item has its sample pair registered through the queue entry, the level stage and the
// output register in turn after acceptance; a write byte gives none.
// Sustained rate: one item per cycle while the sink keeps up, set by the back end's counter update.
// Input ready depends only on queue occupancy; the output register absorbs a stalled sink.
// Reset: periods, counters and noise shifter clear, attenuations go silent, polarities
// positive, stereo enables all set, stereo mode off, queue empty.
// ----------------------------------------------------------------------------
// psg_tone_noise_mixer_core
// Three tone channels and one noise channel mixed to a signed stereo pair.
// ----------------------------------------------------------------------------
module psg_tone_noise_mixer_core #(
	parameter int FULL_SCALE  = 1536,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	psg_in_if.sink      item_in,
	psg_out_if.source   sample_out,
	psg_cfg_if.sink     cfg
);

	psg_pkg::mix_cfg_t mix_cfg_q;
	logic              push_valid;
	logic              push_ready;
	psg_pkg::entry_t   push_entry;
	logic              pop_valid;
	logic              pop_ready;
	psg_pkg::entry_t   pop_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_cfg_q.enables <= 8'hFF;
			mix_cfg_q.mode    <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.index == psg_pkg::CFG_STEREO_ENABLES) begin
				mix_cfg_q.enables <= cfg.wdata;
			end else if (cfg.index == psg_pkg::CFG_STEREO_MODE) begin
				mix_cfg_q.mode <= cfg.wdata[0];
			end
		end
	end

	psg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	psg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	psg_back #(
		.FULL_SCALE (FULL_SCALE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry),
		.mix_cfg    (mix_cfg_q),
		.sample_out (sample_out)
	);

endmodule
